### design/ansi_truecolor_frame_encoder_assert.svh
// Assertion macros used by the ANSI truecolor frame encoder RTL.
// Each macro expands to one labeled concurrent assertion; no dependencies.
`ifndef ANSI_TRUECOLOR_FRAME_ENCODER_ASSERT_SVH
`define ANSI_TRUECOLOR_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define ATFE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ATFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/atfe_pkg.sv
// Package for the ANSI truecolor frame encoder: constants, item types and
// helper functions. No dependencies.
`timescale 1ns / 1ps
package atfe_pkg;

  localparam int DIM_BITS = 10;
  localparam int CFG_W    = 11;
  localparam logic [31:0] DimMax = 32'd1 << DIM_BITS;

  localparam logic [CFG_W-1:0] WidthReset  = CFG_W'(80);
  localparam logic [CFG_W-1:0] HeightReset = CFG_W'(24);

  localparam logic CfgFrameWidth  = 1'b0;
  localparam logic CfgFrameHeight = 1'b1;

  localparam logic [7:0] ChEsc   = 8'h1b;
  localparam logic [7:0] ChLbr   = 8'h5b;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNl    = 8'h0a;
  localparam logic [7:0] ChM     = 8'h6d;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChFour  = 8'h34;
  localparam logic [7:0] ChEight = 8'h38;
  localparam logic [7:0] ChTwo   = 8'h32;

  localparam int IntroLen = 7;
  localparam int ResetLen = 4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] glyph;
    logic       color_chg;
    logic       row_end;
    logic       frame_end;
  } pix_t;

  typedef struct packed {
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
    logic [1:0] num;
  } dec_t;

  // Largest counter value before the row/frame wraps.
  function automatic logic [DIM_BITS-1:0] dim_last(input logic [CFG_W-1:0] r);
    logic [DIM_BITS-1:0] res;
    if (r == '0) begin
      res = '0;
    end else if (32'(r) > DimMax) begin
      res = '1;
    end else begin
      res = DIM_BITS'(32'(r) - 32'd1);
    end
    return res;
  endfunction

  // Decimal split by reciprocal multiplication, exact for 0..255.
  function automatic dec_t to_dec(input logic [7:0] v);
    logic [13:0] ph;
    logic [7:0]  rem;
    logic [14:0] pt;
    dec_t        d;
    ph    = 14'(v) * 14'd41;
    d.hun = {2'b00, ph[13:12]};
    rem   = v - 8'(ph[13:12]) * 8'd100;
    pt    = 15'(rem) * 15'd205;
    d.ten = pt[14:11];
    d.one = 4'(rem - 8'(pt[14:11]) * 8'd10);
    if (v >= 8'd100) begin
      d.num = 2'd3;
    end else if (v >= 8'd10) begin
      d.num = 2'd2;
    end else if (v != 8'd0) begin
      d.num = 2'd1;
    end else begin
      d.num = 2'd0;
    end
    return d;
  endfunction

  function automatic logic [7:0] intro_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = ChEsc;
      3'd1:    b = ChLbr;
      3'd2:    b = ChFour;
      3'd3:    b = ChEight;
      3'd4:    b = ChSemi;
      3'd5:    b = ChTwo;
      default: b = ChSemi;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] reset_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = ChEsc;
      3'd1:    b = ChLbr;
      3'd2:    b = ChZero;
      default: b = ChM;
    endcase
    return b;
  endfunction

endpackage

### design/atfe_front.sv
// Input register stage: takes pixel transactions, tracks column, row and
// previous color, and flags color change and row/frame end. Uses atfe_pkg.
`timescale 1ns / 1ps
module atfe_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [31:0]                     s_tdata_i,
  input  logic [atfe_pkg::DIM_BITS-1:0]   width_last_i,
  input  logic [atfe_pkg::DIM_BITS-1:0]   height_last_i,
  output logic                            item_valid_o,
  output atfe_pkg::pix_t                  item_o,
  input  logic                            item_take_i
);
  import atfe_pkg::*;

  logic                valid_q;
  pix_t                item_q, item_d;
  logic [DIM_BITS-1:0] col_q, col_d;
  logic [DIM_BITS-1:0] row_q, row_d;
  logic [23:0]         prev_q, prev_d;
  logic [23:0]         color;
  logic                accept;

  assign s_tready_o = !valid_q || item_take_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign color      = {s_tdata_i[7:0], s_tdata_i[15:8], s_tdata_i[23:16]};

  always_comb begin
    item_d.red       = s_tdata_i[7:0];
    item_d.green     = s_tdata_i[15:8];
    item_d.blue      = s_tdata_i[23:16];
    item_d.glyph     = s_tdata_i[31:24];
    item_d.color_chg = color != prev_q;
    item_d.row_end   = col_q >= width_last_i;
    item_d.frame_end = item_d.row_end && (row_q >= height_last_i);
    prev_d = item_d.frame_end ? 24'd0 : color;
    col_d  = item_d.row_end ? '0 : col_q + 1'b1;
    if (item_d.frame_end) begin
      row_d = '0;
    end else if (item_d.row_end) begin
      row_d = row_q + 1'b1;
    end else begin
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
      prev_q  <= '0;
    end else begin
      if (accept) begin
        valid_q <= 1'b1;
        col_q   <= col_d;
        row_q   <= row_d;
        prev_q  <= prev_d;
      end else if (item_take_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### design/atfe_serial.sv
// Byte serializer: converts a flagged pixel to its escape sequence, glyph,
// newline and reset bytes, one byte per output transaction. Uses atfe_pkg.
`timescale 1ns / 1ps
`include "ansi_truecolor_frame_encoder_assert.svh"
module atfe_serial (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  atfe_pkg::pix_t item_i,
  output logic           item_take_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output logic [7:0]     m_tdata_o,
  output logic           m_tlast_o,
  output logic           m_tuser_o
);
  import atfe_pkg::*;

  typedef enum logic [2:0] {
    PH_INTRO, PH_RED, PH_GRN, PH_BLU, PH_GLYPH, PH_NL, PH_RST
  } phase_e;

  typedef struct packed {
    dec_t       red;
    dec_t       green;
    dec_t       blue;
    logic [7:0] glyph;
    logic       color_chg;
    logic       row_end;
    logic       frame_end;
  } desc_t;

  logic       busy_q;
  phase_e     phase_q, phase_nx;
  logic [2:0] sub_q, sub_nx;
  desc_t      desc_q, desc_d;
  logic       last, fire, load;
  dec_t       comp;
  logic [7:0] tail;
  logic [1:0] didx;
  logic [3:0] digit;

  always_comb begin
    desc_d.red       = to_dec(item_i.red);
    desc_d.green     = to_dec(item_i.green);
    desc_d.blue      = to_dec(item_i.blue);
    desc_d.glyph     = (item_i.glyph == 8'd0) ? ChSpace : item_i.glyph;
    desc_d.color_chg = item_i.color_chg;
    desc_d.row_end   = item_i.row_end;
    desc_d.frame_end = item_i.frame_end;
  end

  always_comb begin
    case (phase_q)
      PH_RED:  begin comp = desc_q.red;   tail = ChSemi; end
      PH_GRN:  begin comp = desc_q.green; tail = ChSemi; end
      default: begin comp = desc_q.blue;  tail = ChM;    end
    endcase
    didx = 2'(3'd3 - 3'(comp.num) + sub_q);
    case (didx)
      2'd0:    digit = comp.hun;
      2'd1:    digit = comp.ten;
      default: digit = comp.one;
    endcase
  end

  always_comb begin
    phase_nx = phase_q;
    sub_nx   = sub_q + 3'd1;
    last     = 1'b0;
    case (phase_q)
      PH_INTRO: begin
        m_tdata_o = intro_byte(sub_q);
        if (sub_q == 3'(IntroLen - 1)) begin
          phase_nx = PH_RED;
          sub_nx   = '0;
        end
      end
      PH_RED, PH_GRN, PH_BLU: begin
        m_tdata_o = (sub_q < 3'(comp.num)) ? (ChZero + 8'(digit)) : tail;
        if (sub_q == 3'(comp.num)) begin
          sub_nx = '0;
          case (phase_q)
            PH_RED:  phase_nx = PH_GRN;
            PH_GRN:  phase_nx = PH_BLU;
            default: phase_nx = PH_GLYPH;
          endcase
        end
      end
      PH_GLYPH: begin
        m_tdata_o = desc_q.glyph;
        if (desc_q.row_end) begin
          phase_nx = PH_NL;
          sub_nx   = '0;
        end else begin
          last = 1'b1;
        end
      end
      PH_NL: begin
        m_tdata_o = ChNl;
        if (desc_q.frame_end) begin
          phase_nx = PH_RST;
          sub_nx   = '0;
        end else begin
          last = 1'b1;
        end
      end
      default: begin
        m_tdata_o = reset_byte(sub_q);
        last      = sub_q == 3'(ResetLen - 1);
      end
    endcase
  end

  assign m_tvalid_o  = busy_q;
  assign m_tlast_o   = last;
  assign m_tuser_o   = last && (phase_q == PH_RST);
  assign fire        = busy_q && m_tready_i;
  assign load        = item_valid_i && (!busy_q || (fire && last));
  assign item_take_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_GLYPH;
      sub_q   <= '0;
    end else begin
      if (load) begin
        busy_q  <= 1'b1;
        phase_q <= desc_d.color_chg ? PH_INTRO : PH_GLYPH;
        sub_q   <= '0;
      end else if (fire) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          phase_q <= phase_nx;
          sub_q   <= sub_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q <= desc_d;
    end
  end

  `ATFE_ASSERT_SAME(a_done_is_last, clk_i, rst_ni, m_tvalid_o && m_tuser_o, m_tlast_o, "frame end byte not last")
  `ATFE_ASSERT_NEXT(a_load_busy, clk_i, rst_ni, load, busy_q, "load did not start output")
  `ATFE_ASSERT_SAME(a_rst_frame, clk_i, rst_ni, busy_q && (phase_q == PH_RST), desc_q.frame_end, "reset sequence without frame end")
  `ATFE_ASSERT_SAME(a_nl_row, clk_i, rst_ni, busy_q && (phase_q == PH_NL), desc_q.row_end, "newline without row end")

endmodule

### design/ansi_truecolor_frame_encoder.sv
// An accepted pixel is registered in the input stage, then loaded into the
// serializer once it is free. Throughput: one output byte per cycle while
// m_tready_i is high; a pixel gives 1 to 25 bytes; plain pixels then go 1/cycle.
// Reset: asynchronous active low; counters and previous color clear, width 80,
// height 24.
`timescale 1ns / 1ps
module ansi_truecolor_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // red, green, blue, glyph
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,   // out_byte
  output logic        m_tlast_o,
  output logic        m_tuser_o,   // frame_done
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [10:0] cfg_wdata_i
);
  import atfe_pkg::*;

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  logic             item_valid;
  logic             item_take;
  pix_t             item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgFrameWidth:  width_q  <= cfg_wdata_i;
        CfgFrameHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  atfe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid_i),
    .s_tready_o    (s_tready_o),
    .s_tdata_i     (s_tdata_i),
    .width_last_i  (dim_last(width_q)),
    .height_last_i (dim_last(height_q)),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_take_i   (item_take)
  );

  atfe_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .m_tvalid_o   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_o    (m_tdata_o),
    .m_tlast_o    (m_tlast_o),
    .m_tuser_o    (m_tuser_o)
  );

endmodule
